// ----- design/png_stored_deflate_encoder_core_macros.svh -----
// assertion macros shared by the png encoder modules
`ifndef PNG_STORED_DEFLATE_ENCODER_CORE_MACROS_SVH
`define PNG_STORED_DEFLATE_ENCODER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PNGENC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PNGENC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/pngenc_pkg.sv -----
// types, constants and the crc step of the png stored-deflate encoder
package pngenc_pkg;

  localparam int CFG_W  = 14;
  localparam int REM_W  = 28;
  localparam int ROOM_W = 16;

  // opcodes and register indexes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_PIXEL   = 1'b1;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 14'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 14'd480;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_SEED  = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [16:0] BLOCK_MAX = 17'd65535;

  // byte positions of the file head
  localparam logic [5:0] H_IHDR_TAG = 6'd12;
  localparam logic [5:0] H_FRAME_W  = 6'd16;
  localparam logic [5:0] H_FRAME_H  = 6'd20;
  localparam logic [5:0] H_IHDR_END = 6'd28;
  localparam logic [5:0] H_IHDR_CRC = 6'd29;
  localparam logic [5:0] H_IDAT_LEN = 6'd33;
  localparam logic [5:0] H_IDAT_TAG = 6'd37;
  localparam logic [5:0] H_LAST     = 6'd42;

  // byte positions of the file tail
  localparam logic [5:0] T_IDAT_CRC = 6'd4;
  localparam logic [5:0] T_IEND_TAG = 6'd12;
  localparam logic [5:0] T_IEND_CRC = 6'd16;
  localparam logic [5:0] T_LAST     = 6'd19;

  localparam logic [2:0] HDR_LAST = 3'd4;

  // fixed bytes of the head, variable positions hold zero
  localparam logic [0:42][7:0] HEAD_ROM = {
    8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
    8'h00, 8'h00, 8'h00, 8'h0D,
    8'h49, 8'h48, 8'h44, 8'h52,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h08, 8'h02, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h49, 8'h44, 8'h41, 8'h54,
    8'h78, 8'h01
  };

  // fixed bytes of the tail
  localparam logic [0:19][7:0] TAIL_ROM = {
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h49, 8'h45, 8'h4E, 8'h44,
    8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic       opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       file_done;
    logic       misuse;
  } out_item_t;

  // control of the checksum unit for one byte
  typedef struct packed {
    logic crc_restart;
    logic crc_feed;
    logic adler_restart;
    logic adler_feed;
  } sum_ctl_t;

  // one byte through the reflected crc-32
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // big-endian byte of a word
  function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] sel);
    logic [7:0] r;
    case (sel)
      2'd0:    r = w[31:24];
      2'd1:    r = w[23:16];
      2'd2:    r = w[15:8];
      default: r = w[7:0];
    endcase
    return r;
  endfunction

endpackage

// ----- design/pngenc_sum_unit.sv -----
// crc-32 and adler-32 unit, one byte per cycle
module pngenc_sum_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pngenc_pkg::sum_ctl_t ctl,
  input  logic [7:0]           data_byte,
  output logic [31:0]          crc,
  output logic [31:0]          adler
);

  logic [31:0] crc_r, crc_nxt, crc_base;
  logic [15:0] low_r, low_nxt, high_r, high_nxt;
  logic [16:0] low_sum, high_sum, low_mod;

  // crc with optional restart before the byte
  always_comb begin
    crc_base = ctl.crc_restart ? pngenc_pkg::CRC_SEED : crc_r;
    crc_nxt  = ctl.crc_feed ? pngenc_pkg::crc_byte(crc_base, data_byte) : crc_base;
  end

  // adler sums, each kept below the modulus by one compare and subtract
  always_comb begin
    low_sum  = {1'b0, low_r} + {9'd0, data_byte};
    low_mod  = (low_sum >= pngenc_pkg::ADLER_MOD) ? low_sum - pngenc_pkg::ADLER_MOD : low_sum;
    high_sum = {1'b0, high_r} + low_mod;
    low_nxt  = low_r;
    high_nxt = high_r;
    if (ctl.adler_restart) begin
      low_nxt  = 16'd1;
      high_nxt = 16'd0;
    end else if (ctl.adler_feed) begin
      low_nxt  = low_mod[15:0];
      high_nxt = (high_sum >= pngenc_pkg::ADLER_MOD) ?
                 16'(high_sum - pngenc_pkg::ADLER_MOD) : high_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= pngenc_pkg::CRC_SEED;
      low_r  <= 16'd1;
      high_r <= 16'd0;
    end else begin
      crc_r  <= crc_nxt;
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  assign crc   = crc_r;
  assign adler = {high_r, low_r};

`include "png_stored_deflate_encoder_core_macros.svh"

  `PNGENC_ASSERT_NOW(a_adler_low_range, 1'b1, {1'b0, low_r} < pngenc_pkg::ADLER_MOD, "adler low out of range")
  `PNGENC_ASSERT_NOW(a_adler_high_range, 1'b1, {1'b0, high_r} < pngenc_pkg::ADLER_MOD, "adler high out of range")
  `PNGENC_ASSERT_NEXT(a_adler_restart, ctl.adler_restart, adler == 32'd1, "adler not restarted")

endmodule

// ----- design/png_stored_deflate_encoder_core.sv -----
// top level of the streaming png encoder with stored deflate blocks
//
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------------------
//  in       | in_valid/in_ready | in_data: opcode, red, green, blue
//  out      | out_valid/out_ready | out_data: out_byte, run_last, file_done, misuse
//  cfg      | cfg_we            | cfg_index, cfg_wdata (width, height)
//
// one output byte per cycle unless stalled, by a sequencer sharing one checksum unit
// start: size arithmetic (S_MUL multiply, S_DIV block count), then 43 bytes
// pixel: accept, then 3 or 4 bytes, 5 more per stored block header, 20 at end
// in_ready is high only while the sequencer is idle; out_ready low stalls the sequencer
// reset is synchronous active low and opens no frame
module png_stored_deflate_encoder_core #(
  parameter int MAX_WIDTH  = 8192,
  parameter int MAX_HEIGHT = 8192
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pngenc_pkg::in_item_t          in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pngenc_pkg::out_item_t         out_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [pngenc_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int MW  = CW + 2;
  localparam int RLW = HW + MW;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_HEAD = 7'b0001000,
    S_RAW  = 7'b0010000,
    S_TAIL = 7'b0100000,
    S_MIS  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [pngenc_pkg::CFG_W-1:0] cfg_w_r, cfg_h_r;
  logic [CW-1:0]  frame_w_r, frame_w_nxt, col_r, col_nxt, col_inc;
  logic [HW-1:0]  frame_h_r, frame_h_nxt, row_r, row_nxt, row_inc;
  logic           frame_open_r, frame_open_nxt;
  logic [RLW-1:0] raw_len_r, raw_len_nxt;
  logic [16:0]    nb_r, nb_nxt;
  logic [5:0]     idx_r, idx_nxt;
  logic [1:0]     raw_idx_r, raw_idx_nxt;
  logic [2:0]     hdr_cnt_r, hdr_cnt_nxt;
  logic           hdr_done_r, hdr_done_nxt;
  logic           finish_r, finish_nxt;
  logic [23:0]    pix_r, pix_nxt;
  logic [pngenc_pkg::ROOM_W-1:0] room_r, room_nxt;
  logic [pngenc_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic           out_valid_r, out_valid_nxt;
  pngenc_pkg::out_item_t out_r, out_nxt;

  pngenc_pkg::sum_ctl_t sum_ctl;
  logic [7:0]  sum_byte;
  logic [31:0] crc_val, adler_val;

  logic        slot, accept;
  logic [31:0] raw32, idat_size, width_ext, height_ext, cfg_w_ext, cfg_h_ext, crc_out;
  logic [16:0] q_part, r_part, qr_sum, qr_rem, nb_floor;
  logic [15:0] blk_len;
  logic        blk_final;
  logic [7:0]  head_byte, tail_byte, hdr_byte, raw_byte;

  assign slot     = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= pngenc_pkg::WIDTH_RESET;
      cfg_h_r <= pngenc_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == pngenc_pkg::REG_WIDTH) cfg_w_r <= cfg_wdata;
      if (cfg_index == pngenc_pkg::REG_HEIGHT) cfg_h_r <= cfg_wdata;
    end
  end

  // clamped frame size
  assign cfg_w_ext = {18'd0, cfg_w_r};
  assign cfg_h_ext = {18'd0, cfg_h_r};
  always_comb begin
    if (cfg_w_ext == 32'd0)                 frame_w_nxt = CW'(1);
    else if (cfg_w_ext > 32'(MAX_WIDTH))    frame_w_nxt = CW'(MAX_WIDTH);
    else                                    frame_w_nxt = CW'(cfg_w_ext);
    if (cfg_h_ext == 32'd0)                 frame_h_nxt = HW'(1);
    else if (cfg_h_ext > 32'(MAX_HEIGHT))   frame_h_nxt = HW'(MAX_HEIGHT);
    else                                    frame_h_nxt = HW'(cfg_h_ext);
  end

  // raw length and stored block count, x / 65535 via x = q*65536 + r
  assign raw_len_nxt = RLW'(frame_h_r) * (MW'(1) + MW'(3) * MW'(frame_w_r));
  assign raw32       = 32'(raw_len_r);
  assign q_part      = {1'b0, raw32[31:16]};
  assign r_part      = {1'b0, raw32[15:0]};
  assign qr_sum      = q_part + r_part;
  assign qr_rem      = (qr_sum >= pngenc_pkg::BLOCK_MAX) ? qr_sum - pngenc_pkg::BLOCK_MAX : qr_sum;
  assign nb_floor    = q_part + {16'd0, qr_sum >= pngenc_pkg::BLOCK_MAX};
  assign nb_nxt      = nb_floor + {16'd0, qr_rem != 17'd0};
  assign idat_size   = 32'd6 + {15'd0, nb_r} + {13'd0, nb_r, 2'b00} + raw32;
  assign width_ext   = 32'(frame_w_r);
  assign height_ext  = 32'(frame_h_r);
  assign crc_out     = crc_val ^ pngenc_pkg::CRC_SEED;

  // head byte
  always_comb begin
    head_byte = pngenc_pkg::HEAD_ROM[idx_r];
    if (idx_r >= pngenc_pkg::H_FRAME_W && idx_r < pngenc_pkg::H_FRAME_H)
      head_byte = pngenc_pkg::be_byte(width_ext, idx_r[1:0]);
    else if (idx_r >= pngenc_pkg::H_FRAME_H && idx_r < pngenc_pkg::H_FRAME_H + 6'd4)
      head_byte = pngenc_pkg::be_byte(height_ext, idx_r[1:0]);
    else if (idx_r >= pngenc_pkg::H_IHDR_CRC && idx_r < pngenc_pkg::H_IDAT_LEN)
      head_byte = pngenc_pkg::be_byte(crc_out, 2'(idx_r - pngenc_pkg::H_IHDR_CRC));
    else if (idx_r >= pngenc_pkg::H_IDAT_LEN && idx_r < pngenc_pkg::H_IDAT_TAG)
      head_byte = pngenc_pkg::be_byte(idat_size, 2'(idx_r - pngenc_pkg::H_IDAT_LEN));
  end

  // tail byte
  always_comb begin
    if (idx_r < pngenc_pkg::T_IDAT_CRC)
      tail_byte = pngenc_pkg::be_byte(adler_val, idx_r[1:0]);
    else if (idx_r < pngenc_pkg::T_IDAT_CRC + 6'd4 || idx_r >= pngenc_pkg::T_IEND_CRC)
      tail_byte = pngenc_pkg::be_byte(crc_out, idx_r[1:0]);
    else
      tail_byte = pngenc_pkg::TAIL_ROM[5'(idx_r)];
  end

  // stored block header byte and raw byte
  assign blk_final = ({4'd0, rem_r} <= 32'(pngenc_pkg::BLOCK_MAX));
  assign blk_len   = blk_final ? rem_r[15:0] : 16'hFFFF;
  always_comb begin
    case (hdr_cnt_r)
      3'd0:    hdr_byte = {7'd0, blk_final};
      3'd1:    hdr_byte = blk_len[7:0];
      3'd2:    hdr_byte = blk_len[15:8];
      3'd3:    hdr_byte = ~blk_len[7:0];
      default: hdr_byte = ~blk_len[15:8];
    endcase
    case (raw_idx_r)
      2'd0:    raw_byte = 8'd0;
      2'd1:    raw_byte = pix_r[23:16];
      2'd2:    raw_byte = pix_r[15:8];
      default: raw_byte = pix_r[7:0];
    endcase
  end

  assign col_inc = col_r + CW'(1);
  assign row_inc = row_r + HW'(1);

  // byte sequencer
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    raw_idx_nxt    = raw_idx_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    hdr_done_nxt   = hdr_done_r;
    finish_nxt     = finish_r;
    pix_nxt        = pix_r;
    room_nxt       = room_r;
    rem_nxt        = rem_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    frame_open_nxt = frame_open_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    sum_ctl        = '0;
    sum_byte       = 8'd0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.opcode == pngenc_pkg::OP_START) begin
            state_nxt = S_MUL;
          end else if (!frame_open_r) begin
            state_nxt = S_MIS;
          end else begin
            state_nxt    = S_RAW;
            pix_nxt      = {in_data.red, in_data.green, in_data.blue};
            raw_idx_nxt  = (col_r == '0) ? 2'd0 : 2'd1;
            hdr_cnt_nxt  = 3'd0;
            hdr_done_nxt = 1'b0;
            finish_nxt   = 1'b0;
            col_nxt      = col_inc;
            if (col_inc >= frame_w_r) begin
              col_nxt = '0;
              row_nxt = row_inc;
              if (row_inc >= frame_h_r) begin
                row_nxt        = '0;
                finish_nxt     = 1'b1;
                frame_open_nxt = 1'b0;
              end
            end
          end
        end
      end
      S_MUL: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        state_nxt             = S_HEAD;
        idx_nxt               = '0;
        sum_ctl.adler_restart = 1'b1;
        col_nxt               = '0;
        row_nxt               = '0;
        room_nxt              = '0;
        rem_nxt               = raw32[pngenc_pkg::REM_W-1:0];
        frame_open_nxt        = 1'b1;
      end
      S_HEAD: begin
        if (slot) begin
          sum_byte            = head_byte;
          sum_ctl.crc_restart = (idx_r == pngenc_pkg::H_IHDR_TAG) ||
                                (idx_r == pngenc_pkg::H_IDAT_TAG);
          sum_ctl.crc_feed    = (idx_r >= pngenc_pkg::H_IHDR_TAG &&
                                 idx_r <= pngenc_pkg::H_IHDR_END) ||
                                (idx_r >= pngenc_pkg::H_IDAT_TAG);
          out_valid_nxt       = 1'b1;
          out_nxt             = '{out_byte: head_byte, run_last: idx_r == pngenc_pkg::H_LAST,
                                  file_done: 1'b0, misuse: 1'b0};
          idx_nxt             = idx_r + 6'd1;
          if (idx_r == pngenc_pkg::H_LAST) state_nxt = S_IDLE;
        end
      end
      S_RAW: begin
        if (slot) begin
          out_valid_nxt    = 1'b1;
          sum_ctl.crc_feed = 1'b1;
          if (room_r == '0 && !hdr_done_r) begin
            sum_byte = hdr_byte;
            out_nxt  = '{out_byte: hdr_byte, run_last: 1'b0, file_done: 1'b0, misuse: 1'b0};
            if (hdr_cnt_r == pngenc_pkg::HDR_LAST) begin
              hdr_cnt_nxt  = 3'd0;
              hdr_done_nxt = 1'b1;
              room_nxt     = blk_len;
            end else begin
              hdr_cnt_nxt = hdr_cnt_r + 3'd1;
            end
          end else begin
            sum_byte           = raw_byte;
            sum_ctl.adler_feed = 1'b1;
            hdr_done_nxt       = 1'b0;
            if (room_r != '0) room_nxt = room_r - 16'd1;
            if (rem_r != '0)  rem_nxt = rem_r - 28'd1;
            out_nxt = '{out_byte: raw_byte, run_last: (raw_idx_r == 2'd3) && !finish_r,
                        file_done: 1'b0, misuse: 1'b0};
            if (raw_idx_r == 2'd3) begin
              idx_nxt   = '0;
              state_nxt = finish_r ? S_TAIL : S_IDLE;
            end else begin
              raw_idx_nxt = raw_idx_r + 2'd1;
            end
          end
        end
      end
      S_TAIL: begin
        if (slot) begin
          sum_byte            = tail_byte;
          sum_ctl.crc_restart = (idx_r == pngenc_pkg::T_IEND_TAG);
          sum_ctl.crc_feed    = (idx_r < pngenc_pkg::T_IDAT_CRC) ||
                                (idx_r >= pngenc_pkg::T_IEND_TAG &&
                                 idx_r < pngenc_pkg::T_IEND_CRC);
          out_valid_nxt       = 1'b1;
          out_nxt             = '{out_byte: tail_byte, run_last: idx_r == pngenc_pkg::T_LAST,
                                  file_done: idx_r == pngenc_pkg::T_LAST, misuse: 1'b0};
          idx_nxt             = idx_r + 6'd1;
          if (idx_r == pngenc_pkg::T_LAST) state_nxt = S_IDLE;
        end
      end
      S_MIS: begin
        if (slot) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{out_byte: 8'd0, run_last: 1'b1, file_done: 1'b0, misuse: 1'b1};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      frame_open_r <= 1'b0;
      frame_w_r    <= CW'(1);
      frame_h_r    <= HW'(1);
      col_r        <= '0;
      row_r        <= '0;
      room_r       <= '0;
      rem_r        <= '0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
      raw_idx_r    <= '0;
      hdr_cnt_r    <= '0;
      hdr_done_r   <= 1'b0;
      finish_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      frame_open_r <= frame_open_nxt;
      if (accept && in_data.opcode == pngenc_pkg::OP_START) begin
        frame_w_r <= frame_w_nxt;
        frame_h_r <= frame_h_nxt;
      end
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      room_r       <= room_nxt;
      rem_r        <= rem_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
      raw_idx_r    <= raw_idx_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      hdr_done_r   <= hdr_done_nxt;
      finish_r     <= finish_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    pix_r <= pix_nxt;
    if (state_r == S_MUL) raw_len_r <= raw_len_nxt;
    if (state_r == S_DIV) nb_r <= nb_nxt;
  end

  pngenc_sum_unit u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sum_ctl),
    .data_byte (sum_byte),
    .crc       (crc_val),
    .adler     (adler_val)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "png_stored_deflate_encoder_core_macros.svh"

  `PNGENC_ASSERT_NOW(a_misuse_ends_run, out_valid_r && out_r.misuse, out_r.run_last, "misuse byte not last of its run")
  `PNGENC_ASSERT_NOW(a_done_ends_run, out_valid_r && out_r.file_done, out_r.run_last, "file end byte not last of its run")
  `PNGENC_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "input taken while a transaction is in progress")

endmodule

// ----- tb/png_stored_deflate_encoder_core_checker.sv -----
// checker: predicts the png byte stream and compares every output transaction
module png_stored_deflate_encoder_core_checker #(
  parameter int MAX_WIDTH  = 8192,
  parameter int MAX_HEIGHT = 8192
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  pngenc_pkg::in_item_t          in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  pngenc_pkg::out_item_t         out_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [pngenc_pkg::CFG_W-1:0]  cfg_wdata,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // predictor state
  logic [pngenc_pkg::CFG_W-1:0] reg_width, reg_height;
  logic [31:0] idat_crc;
  logic [31:0] sum_a, sum_b;
  logic [31:0] col_cnt, row_cnt, room_left, raw_left;
  logic        in_frame;
  logic [31:0] fw, fh;
  pngenc_pkg::out_item_t png_bytes_due[$];

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? (32'hEDB88320 ^ (c >> 1)) : (c >> 1);
    return c;
  endfunction

  task automatic emit(logic [7:0] b, bit into_crc);
    pngenc_pkg::out_item_t r;
    r = '0;
    r.out_byte = b;
    png_bytes_due.push_back(r);
    if (into_crc) idat_crc = crc_step(idat_crc, b);
  endtask

  task automatic emit32(logic [31:0] v, bit into_crc);
    for (int i = 3; i >= 0; i--) emit(v[i*8 +: 8], into_crc);
  endtask

  task automatic emit_raw(logic [7:0] b);
    logic [31:0] len;
    if (room_left == 32'd0) begin
      len = (raw_left > 32'd65535) ? 32'd65535 : raw_left;
      emit((raw_left <= 32'd65535) ? 8'd1 : 8'd0, 1'b1);
      emit(len[7:0], 1'b1);
      emit(len[15:8], 1'b1);
      emit(~len[7:0], 1'b1);
      emit(~len[15:8], 1'b1);
      room_left = len;
    end
    emit(b, 1'b1);
    sum_a = (sum_a + {24'd0, b}) % 32'd65521;
    sum_b = (sum_b + sum_a) % 32'd65521;
    if (room_left > 32'd0) room_left--;
    if (raw_left > 32'd0) raw_left--;
  endtask

  task automatic predict_item(pngenc_pkg::in_item_t it);
    logic [31:0] raw_len, nblk;
    int first;
    first = png_bytes_due.size();
    if (it.opcode == pngenc_pkg::OP_START) begin
      fw = (reg_width == '0) ? 32'd1 :
           ((32'(reg_width) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(reg_width));
      fh = (reg_height == '0) ? 32'd1 :
           ((32'(reg_height) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(reg_height));
      raw_len = fh * (32'd1 + 32'd3 * fw);
      nblk = (raw_len + 32'd65534) / 32'd65535;
      if (nblk == 32'd0) nblk = 32'd1;
      emit(8'h89, 1'b0); emit(8'h50, 1'b0); emit(8'h4E, 1'b0); emit(8'h47, 1'b0);
      emit(8'h0D, 1'b0); emit(8'h0A, 1'b0); emit(8'h1A, 1'b0); emit(8'h0A, 1'b0);
      emit32(32'd13, 1'b0);
      idat_crc = '1;
      emit32(32'h49484452, 1'b1);
      emit32(fw, 1'b1);
      emit32(fh, 1'b1);
      emit(8'd8, 1'b1); emit(8'd2, 1'b1); emit(8'd0, 1'b1); emit(8'd0, 1'b1);
      emit(8'd0, 1'b1);
      emit32(~idat_crc, 1'b0);
      emit32(32'd2 + 32'd5 * nblk + raw_len + 32'd4, 1'b0);
      idat_crc = '1;
      emit32(32'h49444154, 1'b1);
      emit(8'h78, 1'b1); emit(8'h01, 1'b1);
      sum_a = 32'd1; sum_b = 32'd0; col_cnt = 32'd0; row_cnt = 32'd0; room_left = 32'd0;
      raw_left = raw_len & 32'h0FFFFFFF;
      in_frame = 1'b1;
    end else if (!in_frame) begin
      emit(8'd0, 1'b0);
      png_bytes_due[$].misuse = 1'b1;
    end else begin
      if (col_cnt == 32'd0) emit_raw(8'd0);
      emit_raw(it.red);
      emit_raw(it.green);
      emit_raw(it.blue);
      col_cnt++;
      if (col_cnt >= fw) begin
        col_cnt = 32'd0;
        row_cnt++;
        if (row_cnt >= fh) begin
          row_cnt = 32'd0;
          emit32({sum_b[15:0], sum_a[15:0]}, 1'b1);
          emit32(~idat_crc, 1'b0);
          emit32(32'd0, 1'b0);
          idat_crc = '1;
          emit32(32'h49454E44, 1'b1);
          emit32(~idat_crc, 1'b0);
          png_bytes_due[$].file_done = 1'b1;
          in_frame = 1'b0;
        end
      end
    end
    if (png_bytes_due.size() > first) png_bytes_due[$].run_last = 1'b1;
  endtask

  // watch config writes and both channels
  always @(posedge clk) begin
    pngenc_pkg::out_item_t want;
    if (!rst_n) begin
      reg_width <= pngenc_pkg::WIDTH_RESET;
      reg_height <= pngenc_pkg::HEIGHT_RESET;
      idat_crc = '1; sum_a = 32'd1; sum_b = 32'd0; col_cnt = 32'd0; row_cnt = 32'd0;
      room_left = 32'd0; raw_left = 32'd0; in_frame = 1'b0; fw = 32'd1; fh = 32'd1;
      png_bytes_due.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == pngenc_pkg::REG_WIDTH) reg_width <= cfg_wdata;
        else reg_height <= cfg_wdata;
      end
      if (in_valid && in_ready) predict_item(in_data);
      if (out_valid && out_ready) begin
        if (png_bytes_due.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected output %h", out_data);
        end else begin
          want = png_bytes_due.pop_front();
          if (want !== out_data) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: byte %h/%h last %b/%b done %b/%b misuse %b/%b",
                       want.out_byte, out_data.out_byte, want.run_last,
                       out_data.run_last, want.file_done, out_data.file_done,
                       want.misuse, out_data.misuse);
          end
        end
      end
      pending <= png_bytes_due.size();
    end
  end
endmodule

// ----- tb/png_stored_deflate_encoder_core_tb.sv -----
// testbench top: clock, reset, stimulus and verdict for the png encoder
module png_stored_deflate_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  pngenc_pkg::in_item_t in_data;
  pngenc_pkg::out_item_t out_data;
  logic cfg_we, cfg_index;
  logic [pngenc_pkg::CFG_W-1:0] cfg_wdata;
  int fail_count, pending;
  bit calm, hold_off;

  png_stored_deflate_encoder_core i_dut (.*);

  png_stored_deflate_encoder_core_checker i_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("png_stored_deflate_encoder_core test failed");
    $finish;
  end

  // receiver: random stalls, one long hold-off
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 32);
  end

  // valid stays high after the accept; the next call or an idle task replaces it
  task automatic send(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{op, r, g, b};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_size(logic [pngenc_pkg::CFG_W-1:0] w, logic [pngenc_pkg::CFG_W-1:0] h);
    cfg_we <= 1'b1; cfg_index <= pngenc_pkg::REG_WIDTH; cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= pngenc_pkg::REG_HEIGHT; cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_frame(int w, int h);
    send(pngenc_pkg::OP_START, 8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < w * h; i++)
      send(pngenc_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_data = '0; cfg_we = 0; cfg_index = 0;
    cfg_wdata = '0; calm = 0; hold_off = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: pixel with no frame, smallest frame, extreme channel values
    send(pngenc_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'hAA);
    drain();
    set_size(14'd1, 14'd1);
    send(pngenc_pkg::OP_START, 8'd0, 8'd0, 8'd0);
    send(pngenc_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send(pngenc_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
    drain();
    // zero sizes clamp to 1, abandoned frame
    set_size(14'd0, 14'd0);
    send(pngenc_pkg::OP_START, 8'd0, 8'd0, 8'd0);
    drain();
    set_size(14'd2, 14'd2);
    send(pngenc_pkg::OP_START, 8'd0, 8'd0, 8'd0);
    send(pngenc_pkg::OP_PIXEL, 8'h55, 8'hAA, 8'h0F);
    send(pngenc_pkg::OP_START, 8'd0, 8'd0, 8'd0);
    for (int i = 0; i < 4; i++) send(pngenc_pkg::OP_PIXEL, 8'hF0, 8'h0F, 8'h80);
    drain();
    // big sizes: header with many stored blocks, then clamping above max
    set_size(14'd8192, 14'd8192);
    send(pngenc_pkg::OP_START, 8'd0, 8'd0, 8'd0);
    send(pngenc_pkg::OP_PIXEL, 8'd1, 8'd2, 8'd3);
    drain();
    set_size(14'h3FFF, 14'h3FFF);
    send(pngenc_pkg::OP_START, 8'd0, 8'd0, 8'd0);
    drain();
    // long receiver hold-off while sender keeps offering
    set_size(14'd5, 14'd3);
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_frame(5, 3);
    join
    drain();
    // random small frames, with stray pixels and abandoned starts
    for (int f = 0; f < 15; f++) begin
      int w, h;
      w = $urandom_range(1, 4);
      h = $urandom_range(1, 3);
      calm = (f >= 5 && f < 8);
      set_size(14'(w), 14'(h));
      if ($urandom_range(3) == 0)
        send(pngenc_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
      if ($urandom_range(3) == 0) begin
        send(pngenc_pkg::OP_START, 8'd0, 8'd0, 8'd0);
        send(pngenc_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      random_frame(w, h);
      drain();
    end
    calm = 0;
    drain();
    if (fail_count == 0) $display("png_stored_deflate_encoder_core test passed");
    else $display("png_stored_deflate_encoder_core test failed");
    $finish;
  end
endmodule
